### rtl/wsg_pkg.sv
// Shared types, constants and codes for the three-voice wavetable sound generator.
// No dependencies; every other file in rtl/ except wsg_stream_if refers to this package by scoped names.
package wsg_pkg;

  // Fixed geometry
  localparam int WAVE_LENGTH     = 32;   // samples per wave
  localparam int WAVE_POS_W      = 5;    // bits of a wave position
  localparam int REGISTER_COUNT  = 32;   // sound register file depth
  localparam int REG_AW          = 5;    // register file address width
  localparam int VOICES_WIRED    = 3;    // voices that own registers
  localparam int VOICE_STRIDE    = 5;    // register spacing between voices
  localparam int PHASE_W         = 20;   // phase counter width
  localparam int WSEL_W          = 3;    // wave select bits kept from the register

  // Register map (voice 0 base)
  localparam int REG_FREQ        = 'h10; // lowest frequency nibble of voice 0
  localparam int REG_VOL         = 'h15; // volume
  localparam int REG_WAVE        = 'h05; // wave select

  // Defaults for top-level parameters
  localparam int WAVE_COUNT_DEF  = 8;
  localparam int VOICE_LIMIT_DEF = 8;

  // Reset values and limits
  localparam logic [3:0] SILENT_NIBBLE   = 4'h8;
  localparam logic [3:0] VOICE_COUNT_RST = 4'd3;
  localparam logic [7:0] MIX_GAIN_RST    = 8'd16;
  localparam logic [6:0] AMP_SAT         = 7'd127;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VOICE_COUNT = 1'b0,
    CFG_MIX_GAIN    = 1'b1
  } cfg_idx_e;

  // Command codes of an input item
  typedef enum logic [1:0] {
    CMD_REG_WRITE = 2'd0,
    CMD_TICK      = 2'd1,
    CMD_WAVE_LOAD = 2'd2
  } cmd_e;

  // Channel payloads
  typedef struct packed {
    logic [1:0] command;
    logic [7:0] address;
    logic [3:0] data;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
  } sample_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clear_step;  // write one silent entry of the wave store
    logic take;        // an input transaction completes this cycle
    logic voice_read;  // advance phase of current voice, read its sample
    logic voice_acc;   // accumulate current voice, move to next voice
    logic clamp;       // clamp the sum, split sign and magnitude
    logic mul;         // magnitude times gain
    logic div_step;    // one quotient bit
    logic out_load;    // load the output register
  } ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;  // clearing pass at its last entry
    logic in_tick;     // offered item is a sample tick
    logic voice_last;  // current voice is the last active one
    logic div_last;    // last quotient bit
    logic out_free;    // output register can take a new sample
  } stat_t;

endpackage

### rtl/wsg_stream_if.sv
// Valid/ready stream interface used for the command and sample channels.
// Payload type is a parameter; payload structs come from wsg_pkg.
interface wsg_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/wsg_ctrl.sv
// Sequencing state machine of the wavetable sound generator.
// Depends on wsg_pkg (ctrl_t, stat_t); drives wsg_datapath through ctrl_t.
module wsg_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  wsg_pkg::stat_t stat_i,
  output wsg_pkg::ctrl_t ctrl_o
);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_VREAD = 8'b0000_0100,
    S_VACC  = 8'b0000_1000,
    S_CLAMP = 8'b0001_0000,
    S_MUL   = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode
  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        ctrl_o.clear_step = 1'b1;
        if (stat_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.take = 1'b1;
          if (stat_i.in_tick) state_d = S_VREAD;
        end
      end
      S_VREAD: begin
        ctrl_o.voice_read = 1'b1;
        state_d           = S_VACC;
      end
      S_VACC: begin
        ctrl_o.voice_acc = 1'b1;
        state_d          = stat_i.voice_last ? S_CLAMP : S_VREAD;
      end
      S_CLAMP: begin
        ctrl_o.clamp = 1'b1;
        state_d      = S_MUL;
      end
      S_MUL: begin
        ctrl_o.mul = 1'b1;
        state_d    = S_DIV;
      end
      S_DIV: begin
        ctrl_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = S_OUT;
      end
      S_OUT: begin
        // wait until the previous sample has left
        if (stat_i.out_free) begin
          ctrl_o.out_load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Checks
  a_tick_starts_voices: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && stat_i.in_tick) |=> (state_q == S_VREAD))
    else $error("tick transaction did not start the voice loop");

  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && stat_i.div_last) |=> (state_q == S_OUT))
    else $error("division did not hand over to output");

  a_out_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && !stat_i.out_free) |=> (state_q == S_OUT))
    else $error("sample dropped while output register busy");

endmodule

### rtl/wsg_datapath.sv
// Datapath: sound registers, phase counters, wave store, mixer, scaler, output register.
// Depends on wsg_pkg; steered by wsg_ctrl through ctrl_t, reports through stat_t.
module wsg_datapath #(
  parameter int WAVE_COUNT  = wsg_pkg::WAVE_COUNT_DEF,
  parameter int VOICE_LIMIT = wsg_pkg::VOICE_LIMIT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [wsg_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [wsg_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wsg_pkg::cmd_t                   cmd_i,
  input  wsg_pkg::ctrl_t                  ctrl_i,
  output wsg_pkg::stat_t                  stat_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output wsg_pkg::sample_t                out_data_o
);

  localparam int StoreSize = WAVE_COUNT * wsg_pkg::WAVE_LENGTH;
  localparam int StoreAw   = $clog2(StoreSize);
  localparam int PW        = wsg_pkg::PHASE_W;

  // Configuration registers
  logic [3:0] voice_count_q;
  logic [7:0] mix_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voice_count_q <= wsg_pkg::VOICE_COUNT_RST;
      mix_gain_q    <= wsg_pkg::MIX_GAIN_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == wsg_pkg::CFG_VOICE_COUNT) voice_count_q <= cfg_data_i[3:0];
      if (cfg_idx_i == wsg_pkg::CFG_MIX_GAIN)    mix_gain_q    <= cfg_data_i;
    end
  end

  // Effective voice count and last active voice
  logic [3:0] n_eff;
  logic [1:0] active_last;

  always_comb begin
    if (voice_count_q == 4'd0) n_eff = 4'd1;
    else if (voice_count_q > 4'(VOICE_LIMIT)) n_eff = 4'(VOICE_LIMIT);
    else n_eff = voice_count_q;
    active_last = (n_eff >= 4'(wsg_pkg::VOICES_WIRED)) ? 2'(wsg_pkg::VOICES_WIRED - 1)
                                                         : 2'(n_eff - 4'd1);
  end

  // Sound register file
  logic [3:0] regs_q [wsg_pkg::REGISTER_COUNT];
  logic       reg_we;

  assign reg_we = ctrl_i.take && (cmd_i.command == wsg_pkg::CMD_REG_WRITE)
               && (cmd_i.address[7:wsg_pkg::REG_AW] == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < wsg_pkg::REGISTER_COUNT; i++) regs_q[i] <= 4'h0;
    end else if (reg_we) begin
      regs_q[cmd_i.address[wsg_pkg::REG_AW-1:0]] <= cmd_i.data;
    end
  end

  // Per-voice register fields, at fixed places
  logic [PW-1:0]              freq_v [wsg_pkg::VOICES_WIRED];
  logic [3:0]                 vol_v  [wsg_pkg::VOICES_WIRED];
  logic [wsg_pkg::WSEL_W-1:0] wsel_v [wsg_pkg::VOICES_WIRED];

  always_comb begin
    for (int v = 0; v < wsg_pkg::VOICES_WIRED; v++) begin
      freq_v[v] = {regs_q[5'(wsg_pkg::REG_FREQ + 4 + wsg_pkg::VOICE_STRIDE * v)],
                   regs_q[5'(wsg_pkg::REG_FREQ + 3 + wsg_pkg::VOICE_STRIDE * v)],
                   regs_q[5'(wsg_pkg::REG_FREQ + 2 + wsg_pkg::VOICE_STRIDE * v)],
                   regs_q[5'(wsg_pkg::REG_FREQ + 1 + wsg_pkg::VOICE_STRIDE * v)],
                   (v == 0) ? regs_q[5'(wsg_pkg::REG_FREQ)] : 4'h0};
      vol_v[v]  = regs_q[5'(wsg_pkg::REG_VOL + wsg_pkg::VOICE_STRIDE * v)];
      wsel_v[v] = regs_q[5'(wsg_pkg::REG_WAVE + wsg_pkg::VOICE_STRIDE * v)]
                  [wsg_pkg::WSEL_W-1:0];
    end
  end

  // Current voice selection
  logic [1:0]                 voice_q;
  logic [PW-1:0]              phase_q [wsg_pkg::VOICES_WIRED];
  logic [PW-1:0]              cur_freq, cur_phase, phase_sum;
  logic [3:0]                 cur_vol;
  logic [wsg_pkg::WSEL_W-1:0] cur_wsel;
  logic                       voice_on;

  always_comb begin
    case (voice_q)
      2'd0: begin
        cur_freq = freq_v[0]; cur_vol = vol_v[0]; cur_wsel = wsel_v[0];
        cur_phase = phase_q[0];
      end
      2'd1: begin
        cur_freq = freq_v[1]; cur_vol = vol_v[1]; cur_wsel = wsel_v[1];
        cur_phase = phase_q[1];
      end
      default: begin
        cur_freq = freq_v[2]; cur_vol = vol_v[2]; cur_wsel = wsel_v[2];
        cur_phase = phase_q[2];
      end
    endcase
  end

  assign voice_on  = (cur_vol != 4'h0) && (cur_freq != '0);
  assign phase_sum = cur_phase + cur_freq;

  // Phase counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < wsg_pkg::VOICES_WIRED; i++) phase_q[i] <= '0;
    end else if (ctrl_i.voice_read && voice_on) begin
      phase_q[voice_q] <= phase_sum;
    end
  end

  // Wave store: clearing pass, loads, registered sample read
  logic [3:0]         wave_mem [StoreSize];
  logic [3:0]         rd_q;
  logic [StoreAw-1:0] clr_addr_q;
  logic [7:0]         rd_idx;
  logic               rd_in_range;
  logic               mem_we;
  logic [StoreAw-1:0] mem_waddr;
  logic [3:0]         mem_wdata;

  assign rd_idx      = {cur_wsel, phase_sum[PW-1 -: wsg_pkg::WAVE_POS_W]};
  assign rd_in_range = {24'h0, rd_idx} < 32'(StoreSize);

  assign mem_we    = ctrl_i.clear_step
                  || (ctrl_i.take && (cmd_i.command == wsg_pkg::CMD_WAVE_LOAD)
                      && ({24'h0, cmd_i.address} < 32'(StoreSize)));
  assign mem_waddr = ctrl_i.clear_step ? clr_addr_q : StoreAw'(cmd_i.address);
  assign mem_wdata = ctrl_i.clear_step ? wsg_pkg::SILENT_NIBBLE : cmd_i.data;

  always_ff @(posedge clk_i) begin
    if (mem_we) wave_mem[mem_waddr] <= mem_wdata;
    if (ctrl_i.voice_read) rd_q <= wave_mem[StoreAw'(rd_idx)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (ctrl_i.clear_step) begin
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  // Voice loop and accumulator
  logic              hit_q;
  logic [3:0]        vol_q;
  logic signed [9:0] sum_q;
  logic signed [3:0] amp_s;
  logic signed [4:0] vol_s;
  logic signed [8:0] prod;

  assign amp_s = {~rd_q[3], rd_q[2:0]};  // nibble minus eight
  assign vol_s = {1'b0, vol_q};
  assign prod  = 9'(amp_s) * 9'(vol_s);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voice_q <= 2'd0;
      hit_q   <= 1'b0;
    end else begin
      if (ctrl_i.take) voice_q <= 2'd0;
      else if (ctrl_i.voice_acc) voice_q <= voice_q + 2'd1;
      if (ctrl_i.voice_read) hit_q <= voice_on && rd_in_range;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.voice_read) vol_q <= cur_vol;
    if (ctrl_i.take) sum_q <= '0;
    else if (ctrl_i.voice_acc && hit_q) sum_q <= sum_q + 10'(prod);
  end

  // Clamp to the voice-count range, split into sign and magnitude
  logic signed [11:0] sum_ext, half, lo, hi, clamped, abs_val;
  logic               neg_q;
  logic [10:0]        mag_q;

  always_comb begin
    sum_ext = 12'(sum_q);
    half    = {1'b0, n_eff, 7'b0};
    lo      = -half;
    hi      = half - 12'sd1;
    if (sum_ext < lo) clamped = lo;
    else if (sum_ext > hi) clamped = hi;
    else clamped = sum_ext;
    abs_val = clamped[11] ? -clamped : clamped;
  end

  // Gain multiply, then restoring division by the effective voice count (n_eff) * 16, one bit a cycle
  logic [18:0] rem_q, den_shift;
  logic [7:0]  den, quo_q;
  logic [2:0]  bit_q;

  assign den       = {n_eff, 4'b0};
  assign den_shift = 19'(den) << bit_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.clamp) begin
      neg_q <= clamped[11];
      mag_q <= abs_val[10:0];
    end
    if (ctrl_i.mul) begin
      rem_q <= 19'(mag_q) * 19'(mix_gain_q);
      quo_q <= '0;
    end else if (ctrl_i.div_step && (rem_q >= den_shift)) begin
      rem_q        <= rem_q - den_shift;
      quo_q[bit_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 3'd7;
    end else if (ctrl_i.mul) begin
      bit_q <= 3'd7;
    end else if (ctrl_i.div_step) begin
      bit_q <= bit_q - 3'd1;
    end
  end

  // Saturate, restore sign, output register
  logic [6:0]  val;
  logic [15:0] mag16;
  logic        out_valid_q;
  logic [15:0] out_q;

  assign val   = quo_q[7] ? wsg_pkg::AMP_SAT : quo_q[6:0];
  assign mag16 = {1'b0, val, 8'h00};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) out_q <= neg_q ? (16'h0 - mag16) : mag16;
  end

  assign out_valid_o           = out_valid_q;
  assign out_data_o.sample_out = out_q;

  // Status
  assign stat_o.clear_last = (clr_addr_q == StoreAw'(StoreSize - 1));
  assign stat_o.in_tick    = (cmd_i.command == wsg_pkg::CMD_TICK);
  assign stat_o.voice_last = (voice_q == active_last);
  assign stat_o.div_last   = (bit_q == 3'd0);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  // Checks
  a_out_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.out_load |=> out_valid_q)
    else $error("output register not loaded");

  a_voice_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.voice_acc && !ctrl_i.take) |=> (voice_q == $past(voice_q) + 2'd1))
    else $error("voice index did not advance");

  a_voice_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.voice_read |-> (voice_q <= active_last))
    else $error("voice beyond the active count");

endmodule

### rtl/wavetable_sound_generator_3voice.sv
// Top level of the three-voice wavetable sound generator.
// Depends on wsg_pkg, wsg_stream_if, wsg_ctrl and wsg_datapath.
//
// Usage: cmd_i carries one transaction per command: a sound register write, a
//   waveform store load, or a sample tick. sample_o returns one mixed sample
//   for each tick and nothing for the other commands.
//   cfg_we_i/cfg_idx_i/cfg_data_i write voice_count (index 0) and mix_gain
//   (index 1); write them only while the block is idle.
// Operation: register writes and store loads are taken in the idle state and
//   leave the block idle. A tick runs, in order, the voice loop over the V active
//   voices (V = 1..3), clamp, gain multiply, division and output load; the
//   voice loop runs one voice at a time through the single store read port,
//   and the gain scaling runs one quotient bit per cycle.
// Reset: the waveform store is swept to the silent value, one entry per
//   cycle, over all WAVE_COUNT*32 entries (256 by default); cmd_i.ready stays low
//   meanwhile. Registers, phase counters and configuration take reset values.
// Stalls: a finished sample sits in the output register until taken; the
//   block accepts further writes and loads meanwhile, and a following tick
//   holds its result back until the register is free.
module wavetable_sound_generator_3voice #(
  parameter int WAVE_COUNT  = wsg_pkg::WAVE_COUNT_DEF,
  parameter int VOICE_LIMIT = wsg_pkg::VOICE_LIMIT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [wsg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [wsg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  wsg_stream_if.sink                     cmd_i,
  wsg_stream_if.source                   sample_o
);

  wsg_pkg::ctrl_t   ctrl;
  wsg_pkg::stat_t   stat;
  wsg_pkg::cmd_t    cmd_data;
  wsg_pkg::sample_t smp_data;
  logic             in_ready;
  logic             out_valid;

  assign cmd_data      = cmd_i.data;
  assign cmd_i.ready   = in_ready;
  assign sample_o.valid = out_valid;
  assign sample_o.data  = smp_data;

  wsg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  wsg_datapath #(
    .WAVE_COUNT  (WAVE_COUNT),
    .VOICE_LIMIT (VOICE_LIMIT)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd_data),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .out_valid_o (out_valid),
    .out_ready_i (sample_o.ready),
    .out_data_o  (smp_data)
  );

endmodule
